[hdl/levels_gamma_curve_assert.svh]
// ----------------------------------------------------------------------------
// levels_gamma_curve assertion macros
// Shared property forms for the levels gamma curve block.
// ----------------------------------------------------------------------------
`ifndef LEVELS_GAMMA_CURVE_ASSERT_SVH
`define LEVELS_GAMMA_CURVE_ASSERT_SVH

// same-cycle implication
`define LGC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LGC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/lgc_pkg.sv]
// ----------------------------------------------------------------------------
// lgc_pkg
// Types, register indexes and arithmetic helpers of the levels gamma curve.
// ----------------------------------------------------------------------------
package lgc_pkg;

  typedef enum logic [1:0] {
    SEL_BLACK = 2'd0,
    SEL_WHITE = 2'd1,
    SEL_CURVE = 2'd2
  } lgc_sel_t;

  typedef struct packed {
    logic     vld;
    lgc_sel_t sel;
  } lgc_side_t;

  localparam logic [2:0] REG_IN_BLACK  = 3'd0;
  localparam logic [2:0] REG_IN_WHITE  = 3'd1;
  localparam logic [2:0] REG_INV_GAMMA = 3'd2;
  localparam logic [2:0] REG_OUT_BLACK = 3'd3;
  localparam logic [2:0] REG_OUT_WHITE = 3'd4;

  localparam int DIV_STAGES = 4;
  localparam int LOG_STEPS  = 16;
  localparam int EXP_STEPS  = 16;

  // four restoring division steps: returns {remainder, quotient bits}
  function automatic logic [11:0] div_step(input logic [7:0] rem, input logic [7:0] den);
    logic [8:0] t;
    logic [7:0] r;
    logic [3:0] q;
    r = rem;
    q = '0;
    for (int i = 0; i < 4; i++) begin
      t = {r, 1'b0};
      if (t >= {1'b0, den}) begin
        t = t - {1'b0, den};
        q = {q[2:0], 1'b1};
      end else begin
        q = {q[2:0], 1'b0};
      end
      r = t[7:0];
    end
    return {r, q};
  endfunction

  // square a Q1.30 mantissa and renormalize: returns {fraction bit, mantissa}
  function automatic logic [31:0] sq_step(input logic [30:0] x);
    logic [61:0] p;
    logic [31:0] s;
    p = {31'b0, x} * {31'b0, x};
    s = p[61:30];
    if (s[31]) begin
      return {1'b1, s[31:1]};
    end
    return {1'b0, s[30:0]};
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] res;
    logic [63:0] bitv;
    logic [63:0] rem;
    rem  = x;
    res  = '0;
    bitv = 64'd1 << 62;
    for (int s = 0; s < 32; s++) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Q0.30 factor 2^(-2^(-1-j))
  function automatic logic [29:0] exp_factor(input int j);
    logic [63:0] d;
    d = isqrt64(64'd1 << 59);
    for (int s = 0; s < 16; s++) begin
      if (s < j) begin
        d = isqrt64(d << 30);
      end
    end
    return d[29:0];
  endfunction

  localparam logic [29:0] EXP_D [EXP_STEPS] = '{
    exp_factor(0),  exp_factor(1),  exp_factor(2),  exp_factor(3),
    exp_factor(4),  exp_factor(5),  exp_factor(6),  exp_factor(7),
    exp_factor(8),  exp_factor(9),  exp_factor(10), exp_factor(11),
    exp_factor(12), exp_factor(13), exp_factor(14), exp_factor(15)
  };

endpackage

[hdl/lgc_div.sv]
// ----------------------------------------------------------------------------
// lgc_div
// Pipelined restoring divider: Q0.16 position of the input in its range.
// ----------------------------------------------------------------------------
module lgc_div (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  lgc_pkg::lgc_side_t side_i,
  input  logic [7:0]        num_i,
  input  logic [7:0]        den_i,
  output lgc_pkg::lgc_side_t side_o,
  output logic [15:0]       quo_o
);
  import lgc_pkg::*;

  lgc_side_t   side_r [DIV_STAGES];
  logic [7:0]  rem_r  [DIV_STAGES];
  logic [7:0]  den_r  [DIV_STAGES];
  logic [15:0] quo_r  [DIV_STAGES];
  logic [11:0] step_nxt [DIV_STAGES];

  always_comb begin
    step_nxt[0] = div_step(num_i, den_i);
    for (int s = 1; s < DIV_STAGES; s++) begin
      step_nxt[s] = div_step(rem_r[s-1], den_r[s-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        side_r[s].vld <= 1'b0;
      end
    end else if (en) begin
      side_r[0] <= side_i;
      rem_r[0]  <= step_nxt[0][11:4];
      den_r[0]  <= den_i;
      quo_r[0]  <= {12'b0, step_nxt[0][3:0]};
      for (int s = 1; s < DIV_STAGES; s++) begin
        side_r[s] <= side_r[s-1];
        rem_r[s]  <= step_nxt[s][11:4];
        den_r[s]  <= den_r[s-1];
        quo_r[s]  <= {quo_r[s-1][11:0], step_nxt[s][3:0]};
      end
    end
  end

  assign side_o = side_r[DIV_STAGES-1];
  assign quo_o  = quo_r[DIV_STAGES-1];

endmodule

[hdl/lgc_log.sv]
// ----------------------------------------------------------------------------
// lgc_log
// Pipelined -log2 of a Q0.16 fraction by repeated squaring, Q.16 result.
// ----------------------------------------------------------------------------
module lgc_log (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  lgc_pkg::lgc_side_t side_i,
  input  logic [15:0]       a_i,
  output lgc_pkg::lgc_side_t side_o,
  output logic [20:0]       mag_o
);
  import lgc_pkg::*;

  lgc_side_t   side_r [LOG_STEPS+2];
  logic [30:0] x_r    [LOG_STEPS+1];
  logic [15:0] f_r    [LOG_STEPS+1];
  logic [3:0]  k_r    [LOG_STEPS+1];
  logic [20:0] mag_r;
  logic [3:0]  k_nxt;
  logic [31:0] sq_nxt [LOG_STEPS];

  always_comb begin
    k_nxt = '0;
    for (int b = 0; b < 16; b++) begin
      if (a_i[b]) begin
        k_nxt = 4'(b);
      end
    end
    for (int s = 0; s < LOG_STEPS; s++) begin
      sq_nxt[s] = sq_step(x_r[s]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < LOG_STEPS + 2; s++) begin
        side_r[s].vld <= 1'b0;
      end
    end else if (en) begin
      side_r[0] <= side_i;
      x_r[0]    <= {15'b0, a_i} << (5'd30 - {1'b0, k_nxt});
      f_r[0]    <= '0;
      k_r[0]    <= k_nxt;
      for (int s = 1; s <= LOG_STEPS; s++) begin
        side_r[s] <= side_r[s-1];
        x_r[s]    <= sq_nxt[s-1][30:0];
        f_r[s]    <= {f_r[s-1][14:0], sq_nxt[s-1][31]};
        k_r[s]    <= k_r[s-1];
      end
      side_r[LOG_STEPS+1] <= side_r[LOG_STEPS];
      mag_r <= {(5'd16 - {1'b0, k_r[LOG_STEPS]}), 16'b0} - {5'b0, f_r[LOG_STEPS]};
    end
  end

  assign side_o = side_r[LOG_STEPS+1];
  assign mag_o  = mag_r;

endmodule

[hdl/lgc_exp.sv]
// ----------------------------------------------------------------------------
// lgc_exp
// Pipelined 2^(-e) in Q1.16 from a Q.16 exponent, one factor per stage.
// ----------------------------------------------------------------------------
module lgc_exp (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  lgc_pkg::lgc_side_t side_i,
  input  logic [24:0]       e_i,
  output lgc_pkg::lgc_side_t side_o,
  output logic [16:0]       p_o
);
  import lgc_pkg::*;

  lgc_side_t   side_r [EXP_STEPS+1];
  logic [30:0] y_r    [EXP_STEPS];
  logic [15:0] t_r    [EXP_STEPS];
  logic [8:0]  n_r    [EXP_STEPS];
  logic [16:0] p_r;
  logic [30:0] y_nxt  [EXP_STEPS];
  logic [60:0] prod;
  logic [9:0]  shift;
  logic [30:0] y_in;
  logic        t_bit;

  always_comb begin
    for (int j = 0; j < EXP_STEPS; j++) begin
      y_in  = (j == 0) ? 31'h4000_0000 : y_r[(j == 0) ? 0 : j - 1];
      t_bit = (j == 0) ? e_i[15] : t_r[(j == 0) ? 0 : j - 1][15 - j];
      prod  = {30'b0, y_in} * {31'b0, EXP_D[j]};
      y_nxt[j] = t_bit ? prod[60:30] : y_in;
    end
    shift = {1'b0, n_r[EXP_STEPS-1]} + 10'd14;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j <= EXP_STEPS; j++) begin
        side_r[j].vld <= 1'b0;
      end
    end else if (en) begin
      side_r[0] <= side_i;
      y_r[0]    <= y_nxt[0];
      t_r[0]    <= e_i[15:0];
      n_r[0]    <= e_i[24:16];
      for (int j = 1; j < EXP_STEPS; j++) begin
        side_r[j] <= side_r[j-1];
        y_r[j]    <= y_nxt[j];
        t_r[j]    <= t_r[j-1];
        n_r[j]    <= n_r[j-1];
      end
      side_r[EXP_STEPS] <= side_r[EXP_STEPS-1];
      if (shift >= 10'd40) begin
        p_r <= '0;
      end else begin
        p_r <= 17'(y_r[EXP_STEPS-1] >> shift[5:0]);
      end
    end
  end

  assign side_o = side_r[EXP_STEPS];
  assign p_o    = p_r;

endmodule

[hdl/levels_gamma_curve.sv]
// ----------------------------------------------------------------------------
// levels_gamma_curve
// Levels adjustment with gamma: 8-bit level in, 16-bit level out.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  stream carries one 8-bit level per transfer, out_* stream one
//   16-bit level (8-bit result replicated into both bytes, i.e. times 257).
//   cfg_* writes one register per transfer (index 0..4: in_black, in_white,
//   inv_gamma, out_black, out_white); cfg_ready is always high. Write only
//   while no item is in flight.
//   Throughput: one item per cycle while the output is not stalled. The path
//   from input transfer to out_tvalid runs through the 4-stage divider, 18-stage
//   log2, gamma multiply, 17-stage exp2 and the output stage.
//   Reset: registers return to identity (0, 255, 1.0, 0, 255) and the
//   pipeline empties.
//   Stall: while out_tvalid is high and out_tready low, the whole pipeline
//   holds and in_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module levels_gamma_curve (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] level_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [15:0] level_out
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import lgc_pkg::*;

`include "levels_gamma_curve_assert.svh"

  logic [7:0]  in_black_r;
  logic [7:0]  in_white_r;
  logic [15:0] inv_gamma_r;
  logic [7:0]  out_black_r;
  logic [7:0]  out_white_r;

  logic        en;
  lgc_side_t   in_side;
  lgc_side_t   div_side;
  lgc_side_t   log_side;
  lgc_side_t   gam_side_r;
  lgc_side_t   exp_side;
  logic [15:0] quo;
  logic [20:0] mag;
  logic [24:0] e_r;
  logic [36:0] gam_prod;
  logic [16:0] p;
  logic        out_tvalid_r;
  logic [15:0] out_tdata_r;

  logic signed [9:0]  span;
  logic signed [29:0] num;
  logic [7:0]         r8;
  logic [7:0]         r8_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_black_r  <= 8'd0;
      in_white_r  <= 8'd255;
      inv_gamma_r <= 16'd4096;
      out_black_r <= 8'd0;
      out_white_r <= 8'd255;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_IN_BLACK:  in_black_r  <= cfg_data[7:0];
        REG_IN_WHITE:  in_white_r  <= cfg_data[7:0];
        REG_INV_GAMMA: inv_gamma_r <= cfg_data;
        REG_OUT_BLACK: out_black_r <= cfg_data[7:0];
        REG_OUT_WHITE: out_white_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign en        = !out_tvalid_r || out_tready;
  assign in_tready = en;

  always_comb begin
    in_side.vld = in_tvalid;
    if (in_tdata <= in_black_r) begin
      in_side.sel = SEL_BLACK;
    end else if (in_tdata < in_white_r) begin
      in_side.sel = SEL_CURVE;
    end else begin
      in_side.sel = SEL_WHITE;
    end
  end

  lgc_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .side_i (in_side),
    .num_i  (in_tdata - in_black_r),
    .den_i  (in_white_r - in_black_r),
    .side_o (div_side),
    .quo_o  (quo)
  );

  lgc_log u_log (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .side_i (div_side),
    .a_i    ((quo == 16'd0) ? 16'd1 : quo),
    .side_o (log_side),
    .mag_o  (mag)
  );

  assign gam_prod = {16'b0, mag} * {21'b0, inv_gamma_r} + 37'd2048;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gam_side_r.vld <= 1'b0;
    end else if (en) begin
      gam_side_r <= log_side;
      e_r        <= gam_prod[36:12];
    end
  end

  lgc_exp u_exp (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .side_i (gam_side_r),
    .e_i    (e_r),
    .side_o (exp_side),
    .p_o    (p)
  );

  always_comb begin
    span = $signed({2'b0, out_white_r}) - $signed({2'b0, out_black_r});
    num  = $signed({6'b0, out_black_r, 16'b0}) + 30'(span) * 30'($signed({1'b0, p}));
    if (num < 0) begin
      r8 = 8'd0;
    end else if (num[29:16] > 14'd255) begin
      r8 = 8'd255;
    end else begin
      r8 = num[23:16];
    end
    case (exp_side.sel)
      SEL_BLACK: r8_nxt = out_black_r;
      SEL_CURVE: r8_nxt = r8;
      default:   r8_nxt = out_white_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      out_tvalid_r <= exp_side.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata_r <= {r8_nxt, r8_nxt};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  `LGC_ASSERT_NOW(a_out_bytes_match, out_tvalid, out_tdata[15:8] == out_tdata[7:0], "output bytes differ")
  `LGC_ASSERT_NEXT(a_black_bypass, en && exp_side.vld && exp_side.sel == SEL_BLACK, out_tdata == {out_black_r, out_black_r}, "black bypass wrong")
  `LGC_ASSERT_NEXT(a_white_bypass, en && exp_side.vld && exp_side.sel == SEL_WHITE, out_tdata == {out_white_r, out_white_r}, "white bypass wrong")

endmodule

[tb/levels_gamma_curve_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// levels_gamma_curve_check
// Watches the input and result streams of the levels gamma curve, computes the
// expected 16-bit level of every accepted input with the current register
// values, and compares each result transfer against the oldest expected level.
// ----------------------------------------------------------------------------
module levels_gamma_curve_check (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending
);
  import lgc_pkg::*;

  logic [7:0]  lv_black, lv_white, lv_oblack, lv_owhite;
  logic [15:0] lv_igamma;
  logic [15:0] level_q[$];

  function automatic logic [63:0] root64(input logic [63:0] x);
    logic [63:0] r, b, v;
    v = x;
    r = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] neg_log2(input logic [31:0] a);
    int k;
    logic [63:0] x, f;
    k = 15;
    f = '0;
    while (k > 0 && a[k] == 1'b0) k--;
    x = 64'(a) << (30 - k);
    for (int i = 0; i < 16; i++) begin
      x = (x * x) >> 30;
      f = f << 1;
      if (x >= (64'd2 << 30)) begin
        f = f | 64'd1;
        x = x >> 1;
      end
    end
    return 64'(16 - k) * 64'd65536 - f;
  endfunction

  function automatic logic [31:0] exp2_neg(input logic [63:0] e);
    logic [63:0] y, d, sh;
    y = 64'd1 << 30;
    d = root64(64'd1 << 59);
    for (int i = 15; i >= 0; i--) begin
      if (e[i]) y = (y * d) >> 30;
      d = root64(d << 30);
    end
    sh = (e >> 16) + 64'd14;
    if (sh >= 64'd40) return 32'd0;
    return 32'(y >> sh);
  endfunction

  function automatic logic [15:0] map_level(input logic [7:0] v);
    logic [31:0] r8, a, dv, p;
    logic [63:0] mag, e, q;
    longint num;
    if (v <= lv_black) begin
      r8 = {24'b0, lv_oblack};
    end else if (v < lv_white) begin
      dv = {24'b0, lv_white} - {24'b0, lv_black};
      q = {56'b0, v - lv_black} << 16;
      q = q / {32'b0, dv};
      a = q[31:0];
      if (a == 32'd0) a = 32'd1;
      if (a > 32'd65535) a = 32'd65535;
      mag = neg_log2(a);
      e = (mag * {48'b0, lv_igamma} + 64'd2048) >> 12;
      p = exp2_neg(e);
      num = longint'(lv_oblack) * longint'(65536) +
            (longint'(lv_owhite) - longint'(lv_oblack)) * longint'(p);
      if (num < 0) num = 0;
      r8 = 32'(num >>> 16);
      if (r8 > 32'd255) r8 = 32'd255;
    end else begin
      r8 = {24'b0, lv_owhite};
    end
    return 16'(r8 * 32'd257);
  endfunction

  assign pending = level_q.size();

  always @(posedge clk) begin
    logic [15:0] want;
    if (!rst_n) begin
      lv_black <= 8'd0;
      lv_white <= 8'd255;
      lv_igamma <= 16'd4096;
      lv_oblack <= 8'd0;
      lv_owhite <= 8'd255;
      level_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_IN_BLACK: lv_black <= cfg_data[7:0];
          REG_IN_WHITE: lv_white <= cfg_data[7:0];
          REG_INV_GAMMA: lv_igamma <= cfg_data;
          REG_OUT_BLACK: lv_oblack <= cfg_data[7:0];
          REG_OUT_WHITE: lv_owhite <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) level_q.push_back(map_level(in_tdata));
      if (out_tvalid && out_tready) begin
        if (level_q.size() == 0) begin
          $error("level_out: unexpected transfer, actual %0d", out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          want = level_q.pop_front();
          if (want !== out_tdata) begin
            $error("level_out: expected %0d actual %0d", want, out_tdata);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

[tb/levels_gamma_curve_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// levels_gamma_curve_test
// Drives levels through the gamma curve under several register settings, with
// random gaps on the input and random stalls on the result stream; the
// checker predicts and compares every result.
// ----------------------------------------------------------------------------
module levels_gamma_curve_test;
  import lgc_pkg::*;

  localparam int LATENCY = 41;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk, rst_n;
  logic        in_tvalid, in_tready;
  logic [7:0]  in_tdata;
  logic        out_tvalid, out_tready;
  logic [15:0] out_tdata;
  logic        cfg_valid, cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;
  int          fail_count, pending;
  int          cycle_count = 0;
  bit          stall_on;

  levels_gamma_curve u_dut (.*);

  levels_gamma_curve_check u_check (.*);

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result-side stalls: a random low gap on ready after each accepted result while stall_on is set, or none at all
  always @(posedge clk) begin
    int gap;
    if (!rst_n) begin
      out_tready <= 1'b0;
      gap = 0;
    end else if (out_tready && !out_tvalid) begin
    end else if (out_tready) begin
      if (stall_on) begin
        gap = $urandom_range(0, 4);
        if (gap != 0) out_tready <= 1'b0;
      end
    end else if (gap > 1) begin
      gap--;
    end else begin
      gap = 0;
      out_tready <= 1'b1;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_levels(input logic [7:0] ib, input logic [7:0] iw, input logic [15:0] g,
                            input logic [7:0] ob, input logic [7:0] ow);
    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    write_reg(REG_IN_BLACK, ib);
    write_reg(REG_IN_WHITE, iw);
    write_reg(REG_INV_GAMMA, g);
    write_reg(REG_OUT_BLACK, ob);
    write_reg(REG_OUT_WHITE, ow);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_level(input logic [7:0] v, input bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 4) : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= v;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  initial begin
    stall_on = 1'b1;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // identity curve at reset values
    send_level(8'd0, 0);
    send_level(8'd255, 0);
    send_level(8'd1, 0);
    send_level(8'd128, 0);
    // narrow range, gamma 2.2, inverted output
    set_levels(8'd10, 8'd200, 16'd1862, 8'd250, 8'd5);
    send_level(8'd10, 0);
    send_level(8'd11, 0);
    send_level(8'd199, 0);
    send_level(8'd200, 0);
    send_level(8'd9, 0);
    send_level(8'd100, 0);
    // reversed input range
    set_levels(8'd200, 8'd100, 16'd4096, 8'd30, 8'd220);
    send_level(8'd150, 0);
    send_level(8'd200, 0);
    send_level(8'd201, 0);
    // zero exponent and exponent extremes
    set_levels(8'd0, 8'd255, 16'd0, 8'd0, 8'd255);
    send_level(8'd77, 0);
    set_levels(8'd0, 8'd255, 16'hFFFF, 8'd0, 8'd255);
    send_level(8'd1, 0);
    send_level(8'd254, 0);
    set_levels(8'd0, 8'd255, 16'd410, 8'd255, 8'd0);
    send_level(8'd1, 0);
    send_level(8'd254, 0);
    // adjacent black and white points
    set_levels(8'd100, 8'd101, 16'd40960, 8'd0, 8'd255);
    send_level(8'd100, 0);
    send_level(8'd101, 0);

    for (int ph = 0; ph < 14; ph++) begin
      logic [7:0] ib, iw;
      logic [15:0] g;
      ib = 8'($urandom_range(0, 120));
      iw = 8'($urandom_range(130, 255));
      if (ph % 5 == 4) iw = 8'($urandom_range(0, 255));
      case (ph % 4)
        0: g = 16'($urandom_range(410, 40960));
        1: g = 16'($urandom_range(410, 8192));
        2: g = (ph % 8 == 2) ? 16'hFFFF : 16'd410;
        default: g = 16'($urandom());
      endcase
      set_levels(ib, iw, g, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      stall_on = (ph % 3 != 2);
      for (int n = 0; n < 100; n++) begin
        if (n % 4 == 0) send_level(8'($urandom_range(0, 255)), ph % 3 != 2);
        else send_level(8'($urandom_range(ib, iw)), ph % 3 != 2);
      end
    end
    stall_on = 1'b1;
    in_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
